/* src/bba_pkg.sv */
package bba_pkg;

  localparam int CYLINDERS           = 8;
  localparam int BLOCKS_PER_CYLINDER = 8;
  localparam int RECORDS_PER_TRACK   = 4;
  localparam int TRACKS              = BLOCKS_PER_CYLINDER / RECORDS_PER_TRACK;
  localparam int USABLE_PER_CYL      = TRACKS * RECORDS_PER_TRACK;
  localparam int TOTAL_BLOCKS        = CYLINDERS * USABLE_PER_CYL;
  localparam int MAX_RESULTS         = 64;

  localparam int ROW_W  = $clog2(CYLINDERS);
  localparam int COL_W  = $clog2(BLOCKS_PER_CYLINDER);
  localparam int CNT_W  = 7;
  localparam int FREE_W = 7;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);

  typedef enum logic [2:0] {
    CMD_ALLOC,
    CMD_RELEASE,
    CMD_ZERO,
    CMD_NOSPACE,
    CMD_BADADDR
  } cmd_kind_t;

  typedef enum logic [2:0] {
    STAT_ALLOC    = 3'd0,
    STAT_RELEASED = 3'd1,
    STAT_ZERO     = 3'd2,
    STAT_NOSPACE  = 3'd3,
    STAT_BADADDR  = 3'd4,
    STAT_FREE     = 3'd5
  } status_t;

  typedef struct packed {
    cmd_kind_t        kind;
    logic [CNT_W-1:0] count;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic {
    BK_IDLE,
    BK_SCAN
  } back_state_t;

endpackage

/* src/bba_front.sv */
module bba_front
  import bba_pkg::*;
(
  input  logic        start,
  output logic        busy,
  input  logic        in_req_type,
  input  logic [6:0]  in_block_count,
  input  logic [3:0]  in_cyl_in,
  input  logic [2:0]  in_track_in,
  input  logic [2:0]  in_record_in,
  input  q_stat_t     q_stat,
  output logic        push,
  output cmd_t        push_cmd
);

  logic bad_addr;

  assign busy = q_stat.full;
  assign push = start && !q_stat.full;

  assign bad_addr = (in_cyl_in == 4'd0) || (in_cyl_in > 4'(CYLINDERS)) ||
                    (in_track_in == 3'd0) || (in_track_in > 3'(TRACKS)) ||
                    (in_record_in == 3'd0) || (in_record_in > 3'(RECORDS_PER_TRACK));

  always_comb begin
    push_cmd.count = in_block_count;
    // 0-based row and bit index of the addressed block
    push_cmd.row   = ROW_W'(in_cyl_in - 4'd1);
    push_cmd.col   = COL_W'(32'(in_track_in - 3'd1) * RECORDS_PER_TRACK +
                            32'(in_record_in - 3'd1));
    if (!in_req_type) begin
      if (in_block_count == 7'd0) begin
        push_cmd.kind = CMD_ZERO;
      end else if (in_block_count > 7'(MAX_RESULTS)) begin
        push_cmd.kind = CMD_NOSPACE;
      end else begin
        push_cmd.kind = CMD_ALLOC;
      end
    end else if (bad_addr) begin
      push_cmd.kind = CMD_BADADDR;
    end else begin
      push_cmd.kind = CMD_RELEASE;
    end
  end

endmodule

/* src/bba_queue.sv */
module bba_queue
  import bba_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  cmd_t    push_cmd,
  input  logic    pop,
  output cmd_t    head_cmd,
  output q_stat_t q_stat
);

  cmd_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   cnt_r, cnt_nxt;

  assign q_stat.full  = (cnt_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign q_stat.empty = (cnt_r == '0);
  assign head_cmd     = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

/* src/bba_back.sv */
module bba_back
  import bba_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  q_stat_t     q_stat,
  input  cmd_t        head_cmd,
  output logic        pop,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [3:0]  out_cyl_out,
  output logic [1:0]  out_track_out,
  output logic [2:0]  out_record_out,
  output logic [6:0]  out_free_after,
  output logic        out_last
);

  back_state_t state_r, state_nxt;

  logic [BLOCKS_PER_CYLINDER-1:0] used_r [CYLINDERS];
  logic [BLOCKS_PER_CYLINDER-1:0] used_row_nxt;
  logic                           used_we;
  logic [FREE_W-1:0]              free_r, free_nxt;
  logic [CNT_W-1:0]               cnt_r, cnt_nxt;
  logic [ROW_W-1:0]               row_r, row_nxt;

  logic                           valid_r, valid_nxt;
  status_t                        status_r, status_nxt;
  logic [3:0]                     cyl_r, cyl_nxt;
  logic [1:0]                     trk_r, trk_nxt;
  logic [2:0]                     rec_r, rec_nxt;
  logic [6:0]                     fr_r, fr_nxt;
  logic                           last_r, last_nxt;

  logic [ROW_W-1:0]               rd_row;
  logic [BLOCKS_PER_CYLINDER-1:0] row_bits;
  logic                           any_free;
  logic [COL_W-1:0]               free_col;
  logic [COL_W-1:0]               hit_col;
  logic                           take;
  logic                           alloc_ok;

  assign pop      = (state_r == BK_IDLE) && !q_stat.empty;
  assign take     = (state_r == BK_SCAN) && any_free;
  assign alloc_ok = (head_cmd.count <= free_r);

  // one read port on the bitmap: scan row or addressed row
  assign rd_row   = (state_r == BK_SCAN) ? row_r : head_cmd.row;
  assign row_bits = used_r[rd_row];

  // first free usable block in the row, lowest index wins
  always_comb begin
    any_free = 1'b0;
    free_col = '0;
    for (int j = USABLE_PER_CYL - 1; j >= 0; j--) begin
      if (!row_bits[j]) begin
        any_free = 1'b1;
        free_col = COL_W'(j);
      end
    end
  end

  assign hit_col = (state_r == BK_SCAN) ? free_col : head_cmd.col;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (pop && head_cmd.kind == CMD_ALLOC && alloc_ok) begin
          state_nxt = BK_SCAN;
        end
      end
      BK_SCAN: begin
        if (take && cnt_r == CNT_W'(1)) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    valid_nxt    = 1'b0;
    status_nxt   = STAT_ZERO;
    cyl_nxt      = '0;
    trk_nxt      = '0;
    rec_nxt      = '0;
    fr_nxt       = free_r;
    last_nxt     = 1'b1;
    free_nxt     = free_r;
    cnt_nxt      = cnt_r;
    row_nxt      = row_r;
    used_we      = 1'b0;
    used_row_nxt = row_bits;
    unique case (state_r)
      BK_IDLE: begin
        if (pop) begin
          unique case (head_cmd.kind)
            CMD_ZERO: begin
              valid_nxt  = 1'b1;
              status_nxt = STAT_ZERO;
            end
            CMD_NOSPACE: begin
              valid_nxt  = 1'b1;
              status_nxt = STAT_NOSPACE;
            end
            CMD_BADADDR: begin
              valid_nxt  = 1'b1;
              status_nxt = STAT_BADADDR;
            end
            CMD_RELEASE: begin
              valid_nxt = 1'b1;
              if (!row_bits[hit_col]) begin
                status_nxt = STAT_FREE;
              end else begin
                status_nxt             = STAT_RELEASED;
                used_we                = 1'b1;
                used_row_nxt[hit_col]  = 1'b0;
                free_nxt               = free_r + 1'b1;
                fr_nxt                 = free_r + 1'b1;
                cyl_nxt                = 4'(head_cmd.row) + 4'd1;
                trk_nxt                = 2'(hit_col / RECORDS_PER_TRACK) + 2'd1;
                rec_nxt                = 3'(hit_col % RECORDS_PER_TRACK) + 3'd1;
              end
            end
            CMD_ALLOC: begin
              if (!alloc_ok) begin
                valid_nxt  = 1'b1;
                status_nxt = STAT_NOSPACE;
              end else begin
                cnt_nxt = head_cmd.count;
                row_nxt = '0;
              end
            end
            default: begin
              valid_nxt  = 1'b1;
              status_nxt = STAT_BADADDR;
            end
          endcase
        end
      end
      BK_SCAN: begin
        if (take) begin
          valid_nxt             = 1'b1;
          status_nxt            = STAT_ALLOC;
          used_we               = 1'b1;
          used_row_nxt[hit_col] = 1'b1;
          free_nxt              = free_r - 1'b1;
          fr_nxt                = free_r - 1'b1;
          cnt_nxt               = cnt_r - 1'b1;
          last_nxt              = (cnt_r == CNT_W'(1));
          cyl_nxt               = 4'(row_r) + 4'd1;
          trk_nxt               = 2'(hit_col / RECORDS_PER_TRACK) + 2'd1;
          rec_nxt               = 3'(hit_col % RECORDS_PER_TRACK) + 3'd1;
        end else begin
          // row full, move on
          row_nxt = row_r + 1'b1;
        end
      end
      default: begin
        valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      free_r  <= FREE_W'(TOTAL_BLOCKS);
      valid_r <= 1'b0;
      for (int c = 0; c < CYLINDERS; c++) begin
        used_r[c] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      free_r  <= free_nxt;
      valid_r <= valid_nxt;
      if (used_we) begin
        used_r[rd_row] <= used_row_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    cnt_r    <= cnt_nxt;
    row_r    <= row_nxt;
    status_r <= status_nxt;
    cyl_r    <= cyl_nxt;
    trk_r    <= trk_nxt;
    rec_r    <= rec_nxt;
    fr_r     <= fr_nxt;
    last_r   <= last_nxt;
  end

  assign out_valid      = valid_r;
  assign out_status     = status_r;
  assign out_cyl_out    = cyl_r;
  assign out_track_out  = trk_r;
  assign out_record_out = rec_r;
  assign out_free_after = fr_r;
  assign out_last       = last_r;

endmodule

/* src/bitmap_block_allocator_core.sv */
// Bitmap block allocator over 8 cylinders of 8 blocks (2 tracks of 4 records), all free
// after reset. A request is taken when start is high and busy is low; busy rises only when
// the two-entry request queue is full. Results come out at most one per cycle on out_valid
// with no way to hold them off. A release, zero request, bad address or no-space answer is
// registered onto the outputs as the back end pops it; an allocate of N blocks starts a scan
// that gives N results and steps over each full cylinder row with no result, since the scan
// reads one bitmap row per cycle and retires one block per cycle while that row has one free.
module bitmap_block_allocator_core
  import bba_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_req_type,
  input  logic [6:0]  in_block_count,
  input  logic [3:0]  in_cyl_in,
  input  logic [2:0]  in_track_in,
  input  logic [2:0]  in_record_in,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [3:0]  out_cyl_out,
  output logic [1:0]  out_track_out,
  output logic [2:0]  out_record_out,
  output logic [6:0]  out_free_after,
  output logic        out_last
);

  q_stat_t q_stat;
  logic    push;
  logic    pop;
  cmd_t    push_cmd;
  cmd_t    head_cmd;

  bba_front u_front (
    .start          (start),
    .busy           (busy),
    .in_req_type    (in_req_type),
    .in_block_count (in_block_count),
    .in_cyl_in      (in_cyl_in),
    .in_track_in    (in_track_in),
    .in_record_in   (in_record_in),
    .q_stat         (q_stat),
    .push           (push),
    .push_cmd       (push_cmd)
  );

  bba_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head_cmd (head_cmd),
    .q_stat   (q_stat)
  );

  bba_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_stat         (q_stat),
    .head_cmd       (head_cmd),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_cyl_out    (out_cyl_out),
    .out_track_out  (out_track_out),
    .out_record_out (out_record_out),
    .out_free_after (out_free_after),
    .out_last       (out_last)
  );

endmodule
